FILE: hw/rtl/signed_binary_to_decimal_ascii_defines.svh
// assertion macros used by the checker in sbda_checker.sv
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SBDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SBDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/sbda_pkg.sv
package sbda_pkg;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_NINE  = 8'd57;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage

FILE: hw/rtl/signed_binary_to_decimal_ascii.sv
// one value converts by shift-and-add-3 through one bcd register, then a minus sign goes
// out if negative, then one char per decimal digit position (leading zeros are dropped,
// one position per cycle unless out_ready stalls); a new word is taken only when idle.
// rst (synchronous) returns the sequencer to idle and empties the output register.
module signed_binary_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    char_code,
  output logic                          last_char
);
  import sbda_pkg::*;

  // decimal digits needed for 2^VALUE_WIDTH - 1
  localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BW   = 4 * NDIG;
  localparam int CW   = $clog2(VALUE_WIDTH + 1);
  localparam int DW   = $clog2(NDIG);

  state_t               state;
  logic [VALUE_WIDTH-1:0] mag;
  logic [BW-1:0]        bcd;
  logic [BW-1:0]        bcd_adj;
  logic [CW-1:0]        cnt;
  logic [DW-1:0]        dcnt;
  logic                 neg;
  logic                 started;
  logic [VALUE_WIDTH-1:0] value_u;
  logic [3:0]           top_digit;
  logic                 last_pos;
  logic                 can_load;
  logic                 skip_zero;
  logic                 load_char;

  assign value_u   = value;
  assign top_digit = bcd[BW-1 -: 4];
  assign last_pos  = (dcnt == DW'(NDIG - 1));
  assign can_load  = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);
  assign skip_zero = (top_digit == 4'd0) && !started && !last_pos;
  assign load_char = can_load && ((state == ST_SIGN) || ((state == ST_EMIT) && !skip_zero));

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      started   <= 1'b0;
      cnt       <= '0;
      dcnt      <= '0;
    end else begin
      if (out_valid && out_ready && !load_char) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            neg   <= value_u[VALUE_WIDTH-1];
            mag   <= value_u[VALUE_WIDTH-1] ? (~value_u + 1'b1) : value_u;
            bcd   <= '0;
            cnt   <= CW'(VALUE_WIDTH);
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd <= {bcd_adj[BW-2:0], mag[VALUE_WIDTH-1]};
          mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            dcnt    <= '0;
            started <= 1'b0;
            state   <= neg ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (can_load) begin
            out_valid <= 1'b1;
            char_code <= ASCII_MINUS;
            last_char <= 1'b0;
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (skip_zero) begin
            // leading zero: drop it
            bcd  <= {bcd[BW-5:0], 4'b0000};
            dcnt <= dcnt + 1'b1;
          end else if (can_load) begin
            out_valid <= 1'b1;
            char_code <= ASCII_ZERO + {4'b0000, top_digit};
            last_char <= last_pos;
            started   <= 1'b1;
            bcd       <= {bcd[BW-5:0], 4'b0000};
            dcnt      <= dcnt + 1'b1;
            if (last_pos) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/sbda_checker.sv
`include "signed_binary_to_decimal_ascii_defines.svh"

module sbda_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] char_code,
  input logic       last_char
);
  import sbda_pkg::*;

  logic       char_ok;
  logic       is_minus;
  logic       stalled;
  logic [8:0] out_word;

  assign char_ok  = (char_code == ASCII_MINUS) ||
                    ((char_code >= ASCII_ZERO) && (char_code <= ASCII_NINE));
  assign is_minus = out_valid && (char_code == ASCII_MINUS);
  assign stalled  = out_valid && !out_ready;
  assign out_word = {char_code, last_char};

  `SBDA_ASSERT_NOW(a_char_legal, out_valid, char_ok, "illegal character code")
  `SBDA_ASSERT_NOW(a_minus_not_last, is_minus, !last_char, "minus sign flagged as last")
  `SBDA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready while converting")
  `SBDA_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_word), "stalled word changed")

endmodule

bind signed_binary_to_decimal_ascii sbda_checker u_sbda_checker (.*);

FILE: dv/signed_binary_to_decimal_ascii_checker.sv
`timescale 1ns / 100ps

module signed_binary_to_decimal_ascii_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [7:0]             char_code,
  input  logic                   last_char,
  output int                     mismatches,
  output int                     pending
);
  import sbda_pkg::*;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  text_char_t expected_chars[$];
  int         error_total = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_total++;
  endtask

  // queue the decimal text of one word, sign first, most significant digit next
  function automatic void queue_decimal_text(input logic [VALUE_WIDTH-1:0] word);
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [3:0]             digits [0:23];
    logic                   negative;
    int                     ndigits;
    int                     total;
    int                     pos;
    text_char_t             ch;
    negative  = word[VALUE_WIDTH-1];
    // unsigned negation keeps the most negative value intact
    magnitude = negative ? (~word + 1'b1) : word;
    ndigits   = 0;
    do begin
      digits[ndigits] = 4'(magnitude % 10);
      ndigits++;
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    total = ndigits + (negative ? 1 : 0);
    pos   = 0;
    if (negative) begin
      ch.code = ASCII_MINUS;
      ch.last = (total == 1);
      expected_chars = {expected_chars, ch};
      pos++;
    end
    for (int k = ndigits - 1; k >= 0; k--) begin
      ch.code = ASCII_ZERO + 8'(digits[k]);
      ch.last = (pos == total - 1);
      expected_chars = {expected_chars, ch};
      pos++;
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        queue_decimal_text(value);
      end
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected char_code", char_code, -1);
        end else begin
          want = expected_chars.pop_front();
          if (char_code !== want.code) begin
            report_mismatch("char_code", char_code, want.code);
          end
          if (last_char !== want.last) begin
            report_mismatch("last_char", last_char, want.last);
          end
        end
      end
    end
    pending    <= expected_chars.size();
    mismatches <= error_total;
  end

endmodule

FILE: dv/signed_binary_to_decimal_ascii_tb.sv
`timescale 1ns / 100ps

module signed_binary_to_decimal_ascii_tb;

  localparam int VALUE_WIDTH  = 32;
  localparam int RANDOM_WORDS = 200;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 64;
  localparam int QUIET_LIMIT  = 4000;

  localparam logic [31:0] DIRECTED [0:19] = '{
    32'd0,          32'd1,          32'hFFFF_FFFF,  32'd9,
    32'd10,         32'hFFFF_FFF6,  32'd99,         32'd100,
    32'h7FFF_FFFF,  32'h8000_0000,  32'h8000_0001,  32'd1000000000,
    32'hC465_3600,  32'd999999999,  32'h5555_5555,  32'hAAAA_AAAA,
    32'hFFFF_FFF9,  32'd12345,      32'd2000000000, 32'hFFFF_FFF7
  };

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          out_valid;
  logic                          out_ready;
  logic [7:0]                    char_code;
  logic                          last_char;

  logic quiet_mode;
  logic hold_request;
  int   mismatches;
  int   pending;
  int   idle_cycles = 0;

  always #1 clk = ~clk;

  signed_binary_to_decimal_ascii #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .char_code(char_code),
    .last_char(last_char)
  );

  signed_binary_to_decimal_ascii_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) text_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .last_char (last_char),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // offer one word, with random gaps ahead of it unless quiet
  task automatic send_word(input logic [31:0] word);
    if (!quiet_mode) begin
      while ($urandom_range(99) < 36) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    value    <= word;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering and wait until every queued char has come out
  task automatic drain_text;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] random_word;
    logic [31:0] word;
    logic [31:0] pow10;
    pow10 = 32'd1;
    case ($urandom_range(3))
      0: word = $urandom;
      1: word = $urandom_range(1999) - 32'd1000;
      2: begin
        // around a digit-count boundary
        repeat ($urandom_range(9)) pow10 = pow10 * 10;
        word = pow10 + $urandom_range(2) - 32'd1;
        if ($urandom_range(1)) word = -word;
      end
      default: begin
        word = $urandom >> $urandom_range(31);
        if ($urandom_range(1)) word = -word;
      end
    endcase
    return word;
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request <= 1'b0;
      end else begin
        out_ready <= quiet_mode || ($urandom_range(99) >= 36);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    value        <= '0;
    quiet_mode   <= 1'b0;
    hold_request <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      send_word(DIRECTED[i]);
    end

    // sender pause until the output side is empty
    drain_text();

    // long receiver hold-off while words keep coming
    hold_request <= 1'b1;
    repeat (6) send_word(random_word());

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 60) quiet_mode <= 1'b1;
      if (n == 100) quiet_mode <= 1'b0;
      send_word(random_word());
    end

    drain_text();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
